// ===== rtl/des_block_cipher_top_assert.svh =====
// Assertion macros used by the port-level checker
`ifndef DES_BLOCK_CIPHER_TOP_ASSERT_SVH
`define DES_BLOCK_CIPHER_TOP_ASSERT_SVH
// implication checked every clock outside reset
`define DES_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define DES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/des_pkg.sv =====
// Package: DES tables, stage types and the round function
`default_nettype none
package des_pkg;
	localparam int NumRounds = 16;

	typedef logic [63:0] blk_t;
	typedef logic [47:0] subkey_t;
	typedef logic [27:0] half_t;

	// one pipeline stage payload
	typedef struct packed {
		logic        vld;
		logic        dec;
		logic [31:0] l;
		logic [31:0] r;
	} stage_t;

	localparam logic [7:0] IP_TAB [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
	localparam logic [7:0] FP_TAB [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
	localparam logic [7:0] E_TAB [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
	localparam logic [7:0] P_TAB [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
	localparam logic [7:0] PC1_TAB [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
	localparam logic [7:0] PC2_TAB [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
	localparam logic [1:0] SHIFT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
	localparam logic [3:0] SBOX_TAB [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
		  0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
		  15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
		  3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
		  13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
		  13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
		  1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
		  13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
		  3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
		  14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
		  11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
		  10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
		  4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
		  13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
		  6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
		  1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
		  2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// table positions count from 1 at the MSB; 64 - pos taken modulo 64
	function automatic blk_t perm64(input logic [7:0] tab [64], input blk_t src);
		blk_t acc;
		acc = '0;
		for (int k = 0; k < 64; k++) acc[63-k] = src[6'd0 - tab[k][5:0]];
		return acc;
	endfunction

	function automatic logic [55:0] pc1(input blk_t key);
		logic [55:0] acc;
		acc = '0;
		for (int k = 0; k < 56; k++) acc[55-k] = key[6'd0 - PC1_TAB[k][5:0]];
		return acc;
	endfunction

	function automatic subkey_t pc2(input logic [55:0] cd);
		subkey_t acc;
		acc = '0;
		for (int k = 0; k < 48; k++) acc[47-k] = cd[6'd56 - PC2_TAB[k][5:0]];
		return acc;
	endfunction

	function automatic half_t rot28(input half_t v, input logic [1:0] s);
		half_t res;
		res = (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
		return res;
	endfunction

	// Feistel function: E, key mix, S-boxes, P (32 - pos taken modulo 32)
	function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
		logic [47:0] x;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0]  six;
		x = '0;
		for (int k2 = 0; k2 < 48; k2++) x[47-k2] = r[5'd0 - E_TAB[k2][4:0]];
		x = x ^ k;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			six = x[47-6*i -: 6];
			s[31-4*i -: 4] = SBOX_TAB[i][{six[5], six[0], six[4:1]}];
		end
		p = '0;
		for (int k3 = 0; k3 < 32; k3++) p[31-k3] = s[5'd0 - P_TAB[k3][4:0]];
		return p;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/des_key_sched.sv =====
// Key schedule: sixteen registered subkeys built from the written key value
`default_nettype none
module des_key_sched (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 key_we,
	input  wire des_pkg::blk_t        key_value,
	output des_pkg::subkey_t          subkeys [des_pkg::NumRounds]
);
	des_pkg::half_t c_w [des_pkg::NumRounds];
	des_pkg::half_t d_w [des_pkg::NumRounds];
	logic [55:0]    pk_w;
	des_pkg::subkey_t sub_q [des_pkg::NumRounds];

	// rotated halves per round
	always_comb begin
		pk_w = des_pkg::pc1(key_value);
		c_w[0] = des_pkg::rot28(pk_w[55:28], des_pkg::SHIFT_TAB[0]);
		d_w[0] = des_pkg::rot28(pk_w[27:0], des_pkg::SHIFT_TAB[0]);
		for (int r = 1; r < des_pkg::NumRounds; r++) begin
			c_w[r] = des_pkg::rot28(c_w[r-1], des_pkg::SHIFT_TAB[r]);
			d_w[r] = des_pkg::rot28(d_w[r-1], des_pkg::SHIFT_TAB[r]);
		end
	end

	// subkeys reload on a key write; reset key is zero so subkeys are zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < des_pkg::NumRounds; r++) sub_q[r] <= '0;
		end else if (key_we) begin
			for (int r = 0; r < des_pkg::NumRounds; r++) sub_q[r] <= des_pkg::pc2({c_w[r], d_w[r]});
		end
	end

	assign subkeys = sub_q;
endmodule
`default_nettype wire

// ===== rtl/des_round.sv =====
// One Feistel round stage with stall-aware register
`default_nettype none
module des_round (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  des_pkg::stage_t       din,
	input  des_pkg::subkey_t      key_enc,
	input  des_pkg::subkey_t      key_dec,
	output des_pkg::stage_t       dout
);
	des_pkg::stage_t stg_s1;
	des_pkg::subkey_t k_w;

	// pick subkey by direction, then one round
	assign k_w = din.dec ? key_dec : key_enc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_s1 <= '0;
		end else if (adv) begin
			stg_s1.vld <= din.vld;
			stg_s1.dec <= din.dec;
			stg_s1.l   <= din.r;
			stg_s1.r   <= din.l ^ des_pkg::feistel(din.r, k_w);
		end
	end

	assign dout = stg_s1;
endmodule
`default_nettype wire

// ===== rtl/des_block_cipher_top.sv =====
// DES ECB engine: input IP stage, sixteen round stages, FP output register
//
// Channels: in (in_valid/in_ready, req_type, block_in), out (out_valid/
// out_ready, block_out) and cfg (cfg_valid/cfg_ready, cfg_data = 64-bit key).
// req_type 0 encrypts, 1 decrypts. Key parity bits are ignored.
// Path from input transfer to out_valid: IP register, 16 round registers,
// output register. Throughput: one block per cycle unless stalled; each
// round stage is one Feistel round, so one round's S-box path sets it.
// The whole pipeline advances together: when out_ready is low and the output
// register holds a block, all stages hold and in_ready drops; bubbles are
// not squeezed out. Nothing is lost or repeated across a stall.
// Key writes are taken in any cycle; subkeys hold the new key from the cycle
// after the write, so write the key only while the pipeline is empty.
// Reset clears all valid bits and sets the subkeys to zero.
`default_nettype none
module des_block_cipher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        req_type,
	input  wire logic [63:0] block_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      block_out,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [63:0] cfg_data
);
	des_pkg::subkey_t subkeys [des_pkg::NumRounds];
	des_pkg::stage_t  chain [des_pkg::NumRounds + 1];
	des_pkg::stage_t  ip_s1;
	des_pkg::blk_t    ip_w;
	logic             adv;
	logic             out_vld_q;
	des_pkg::blk_t    out_q;

	// global advance: output slot free or being drained
	assign adv       = !out_vld_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	des_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .key_we(cfg_valid), .key_value(cfg_data),
		.subkeys(subkeys)
	);

	// initial permutation stage
	assign ip_w = des_pkg::perm64(des_pkg::IP_TAB, block_in);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_s1 <= '0;
		end else if (adv) begin
			ip_s1.vld <= in_valid;
			ip_s1.dec <= req_type;
			ip_s1.l   <= ip_w[63:32];
			ip_s1.r   <= ip_w[31:0];
		end
	end
	assign chain[0] = ip_s1;

	// sixteen round stages
	for (genvar g = 0; g < des_pkg::NumRounds; g++) begin : g_round
		des_round u_rnd (
			.clk(clk), .arst_n(arst_n), .adv(adv), .din(chain[g]),
			.key_enc(subkeys[g]), .key_dec(subkeys[des_pkg::NumRounds - 1 - g]),
			.dout(chain[g+1])
		);
	end

	// swap, final permutation, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= chain[des_pkg::NumRounds].vld;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= des_pkg::perm64(des_pkg::FP_TAB,
				{chain[des_pkg::NumRounds].r, chain[des_pkg::NumRounds].l});
		end
	end

	assign out_valid = out_vld_q;
	assign block_out = out_q;
endmodule
`default_nettype wire

// ===== rtl/des_block_cipher_chk.sv =====
// Port-level checker for the DES engine, bound to the top level
`default_nettype none
`include "des_block_cipher_top_assert.svh"
module des_block_cipher_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] block_out,
	input wire logic        cfg_ready
);
	// a stalled result holds its value
	`DES_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(block_out))
	// input is open whenever the output slot is empty or drains
	`DES_ASSERT_IMPL(a_in_open, clk, arst_n, !out_valid || out_ready, in_ready)
	// stall on the output backs up the input
	`DES_ASSERT_IMPL(a_in_block, clk, arst_n, out_valid && !out_ready, !in_ready)
	// key port always open
	`DES_ASSERT_IMPL(a_cfg_open, clk, arst_n, 1'b1, cfg_ready)
	// an offered result carries a fully known block
	`DES_ASSERT_IMPL(a_out_known, clk, arst_n, out_valid, !$isunknown(block_out))
endmodule

bind des_block_cipher_top des_block_cipher_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .block_out(block_out),
	.cfg_ready(cfg_ready)
);
`default_nettype wire
